>>> src/nearest_point_search_3d_macros.svh
// Assertion macros shared by the nearest point search blocks.
// Each macro expects clk_i and rst_ni to be visible in the including module.
`ifndef NEAREST_POINT_SEARCH_3D_MACROS_SVH
`define NEAREST_POINT_SEARCH_3D_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NPS_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NPS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> src/nps_pkg.sv
// Package for the nearest point search block: sizes, codes, beat payloads
// and the command and status bundles between controller and datapath.
`timescale 1ns / 1ps

package nps_pkg;

  localparam int LOG_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

  localparam int COORD_W   = 28;
  localparam int ID_W      = 20;
  localparam int HEAD_W    = 16;
  localparam int ACT_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int IDX_OUT_W = 10;

  // Absolute difference, square and sum of three squares.
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * COORD_W + 1;
  localparam int SUM_W     = SQ_W + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_LOADED  = 3'd0,
    STS_FULL    = 3'd1,
    STS_MATCH   = 3'd2,
    STS_EMPTY   = 3'd3,
    STS_CLEARED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic        [ACT_W-1:0]  action;
    logic        [ID_W-1:0]   wp_tag;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic        [HEAD_W-1:0] heading;
  } in_beat_t;

  typedef struct packed {
    logic        [STATUS_W-1:0]  status;
    logic        [ID_W-1:0]      result_id;
    logic signed [COORD_W-1:0]   match_x;
    logic signed [COORD_W-1:0]   match_y;
    logic signed [COORD_W-1:0]   match_z;
    logic        [HEAD_W-1:0]    match_heading;
    logic        [IDX_OUT_W-1:0] match_index;
  } out_beat_t;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_issue;
    logic fetch;
    logic out_load;
  } nps_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             empty;
    logic             last_addr;
    logic             pipe_empty;
  } nps_sts_t;

endpackage

>>> src/nps_ifs.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on nps_pkg for the payload types.
`timescale 1ns / 1ps

interface nps_in_if import nps_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nps_out_if import nps_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/nps_datapath.sv
// Datapath: point memory, point count, distance pipeline, best-match
// tracking and the result register. Depends on nps_pkg and the macro header.
`timescale 1ns / 1ps
`include "nearest_point_search_3d_macros.svh"

module nps_datapath import nps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_beat_t  in_data_i,
  input  nps_cmd_t  cmd_i,
  output nps_sts_t  sts_o,
  output out_beat_t out_data_o
);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic        [HEAD_W-1:0]  heading;
  } entry_t;

  entry_t mem [LOG_DEPTH];
  entry_t rd_q;

  in_beat_t  item_q;
  out_beat_t out_q, out_d;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] scan_addr_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;
  logic              full;
  logic              wr_en;

  // Distance pipeline: read, absolute difference, square, sum, compare.
  logic              v1_q, v2_q, v3_q, v4_q;
  logic [ADDR_W-1:0] idx1_q, idx2_q, idx3_q, idx4_q;
  logic [DIFF_W-1:0] absx_q, absy_q, absz_q;
  logic [DIFF_W-1:0] absx_d, absy_d, absz_d;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q;
  logic [SUM_W-1:0]  sum_q;

  logic              best_have_q;
  logic [SUM_W-1:0]  best_dist_q;
  logic [ADDR_W-1:0] best_idx_q;
  logic              take_best;
  logic              pipe_empty;

  assign full       = (count_q == CNT_W'(LOG_DEPTH));
  assign pipe_empty = !(v1_q || v2_q || v3_q || v4_q);
  assign rd_en      = cmd_i.scan_issue || cmd_i.fetch;
  assign rd_addr    = cmd_i.fetch ? best_idx_q : scan_addr_q;
  assign wr_en      = cmd_i.out_load && (item_q.action == ACT_LOAD) && !full;

  assign sts_o.act        = item_q.action;
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.last_addr  = (CNT_W'(scan_addr_q) == count_q - CNT_W'(1));
  assign sts_o.pipe_empty = pipe_empty;
  assign out_data_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[ADDR_W-1:0]] <= '{x: item_q.pos_x, y: item_q.pos_y,
                                    z: item_q.pos_z, heading: item_q.heading};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.out_load) begin
      if (item_q.action == ACT_CLEAR) begin
        count_d = '0;
      end else if (wr_en) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_addr_q <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.scan_start) begin
        scan_addr_q <= '0;
      end else if (cmd_i.scan_issue) begin
        scan_addr_q <= scan_addr_q + ADDR_W'(1);
      end
      v1_q <= cmd_i.scan_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Differences are one bit wider than a coordinate, so nothing wraps; the
  // magnitude of the most negative difference still fits unsigned.
  always_comb begin
    dx = DIFF_W'(item_q.pos_x) - DIFF_W'(rd_q.x);
    dy = DIFF_W'(item_q.pos_y) - DIFF_W'(rd_q.y);
    dz = DIFF_W'(item_q.pos_z) - DIFF_W'(rd_q.z);
    absx_d = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    absy_d = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    absz_d = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= scan_addr_q;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
    absx_q <= absx_d;
    absy_q <= absy_d;
    absz_q <= absz_d;
    sqx_q  <= SQ_W'(absx_q * absx_q);
    sqy_q  <= SQ_W'(absy_q * absy_q);
    sqz_q  <= SQ_W'(absz_q * absz_q);
    sum_q  <= SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);
  end

  // Strictly smaller only, so the lowest index wins a tie.
  assign take_best = v4_q && (!best_have_q || (sum_q < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_have_q <= 1'b0;
      best_dist_q <= '0;
      best_idx_q  <= '0;
    end else if (cmd_i.scan_start) begin
      best_have_q <= 1'b0;
    end else if (take_best) begin
      best_have_q <= 1'b1;
      best_dist_q <= sum_q;
      best_idx_q  <= idx4_q;
    end
  end

  always_comb begin
    out_d = '0;
    case (action_e'(item_q.action))
      ACT_LOAD: begin
        out_d.status = full ? STS_FULL : STS_LOADED;
      end
      ACT_CLEAR: begin
        out_d.status = STS_CLEARED;
      end
      ACT_QUERY: begin
        out_d.result_id = item_q.wp_tag;
        if (count_q == '0) begin
          out_d.status = STS_EMPTY;
        end else begin
          out_d.status        = STS_MATCH;
          out_d.match_x       = rd_q.x;
          out_d.match_y       = rd_q.y;
          out_d.match_z       = rd_q.z;
          out_d.match_heading = rd_q.heading;
          out_d.match_index   = IDX_OUT_W'(best_idx_q);
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  `NPS_ASSERT_IMPL(a_result_after_drain, cmd_i.out_load, pipe_empty, "result loaded with scan in flight")
  `NPS_ASSERT_NEXT(a_full_keeps_count, cmd_i.out_load && item_q.action == ACT_LOAD && full, $stable(count_q), "count moved on a dropped load")
  `NPS_ASSERT_NEXT(a_best_only_on_compare, !v4_q && !cmd_i.scan_start, $stable(best_dist_q) && $stable(best_idx_q), "best match changed without a compare")

endmodule

>>> src/nps_ctrl.sv
// Controller: sequences capture, scan, drain, best fetch and result load,
// and owns both handshakes. Depends on nps_pkg and the macro header.
`timescale 1ns / 1ps
`include "nearest_point_search_3d_macros.svh"

module nps_ctrl import nps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  nps_sts_t sts_i,
  output nps_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can be refilled in the cycle its beat leaves.
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (action_e'(sts_i.act))
          ACT_LOAD, ACT_CLEAR: begin
            state_d = ST_FINISH;
          end
          ACT_QUERY: begin
            if (sts_i.empty) begin
              state_d = ST_FINISH;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Once the last compare has landed, read back the winning entry.
        if (sts_i.pipe_empty) begin
          cmd_o.fetch = 1'b1;
          state_d     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  `NPS_ASSERT_IMPL(a_scan_needs_points, state_q == ST_SCAN, !sts_i.empty, "scan running on an empty table")
  `NPS_ASSERT_NEXT(a_finish_waits, state_q == ST_FINISH && out_valid_q && !out_ready_i, state_q == ST_FINISH, "result overwritten before its beat left")
  `NPS_ASSERT_NEXT(a_load_raises_valid, cmd_o.out_load, out_valid_q, "result loaded but not offered")

endmodule

>>> src/nearest_point_search_3d.sv
// Channel   Dir  Carries
// in_i      in   action, wp_tag, pos_x, pos_y, pos_z, heading
// out_o     out  status, result_id, match_x/y/z, match_heading, match_index
//
// One item is worked at a time. Load and clear go through the dispatch and
// finish states to the result; a query scans the stored points through the
// single read port of the point memory, which feeds one point per cycle into
// the distance pipeline. Reset is asynchronous, active low, and empties the
// table. A new item is accepted while a finished result still waits on out_o.
// Top level of the nearest point search; depends on nps_pkg, the channel
// interfaces, nps_ctrl and nps_datapath.
`timescale 1ns / 1ps

module nearest_point_search_3d import nps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  nps_in_if.sink    in_i,
  nps_out_if.source out_o
);

  nps_cmd_t  cmd;
  nps_sts_t  sts;
  logic      in_ready;
  logic      out_valid;
  out_beat_t out_data;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  nps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nps_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data)
  );

endmodule
